// ===== hw/rtl/pressure_temperature_compensation_defines.svh =====
// ---------------------------------------------------------------------------
// Assertion macros for the pressure/temperature compensation block
// Concurrent checks, compiled out when SYNTHESIS is defined.
// ---------------------------------------------------------------------------
`ifndef PRESSURE_TEMPERATURE_COMPENSATION_DEFINES_SVH
`define PRESSURE_TEMPERATURE_COMPENSATION_DEFINES_SVH

`ifndef SYNTHESIS
// implication in the same cycle, skipped while reset is high
`define PTC_ASSERT_IMP(lbl, clk, rst, a, c) \
  lbl: assert property (@(posedge clk) disable iff (rst) (a) |-> (c)) \
    else $error("ptc assertion failed");
// implication in the next cycle, skipped while reset is high
`define PTC_ASSERT_NEXT(lbl, clk, rst, a, c) \
  lbl: assert property (@(posedge clk) disable iff (rst) (a) |=> (c)) \
    else $error("ptc assertion failed");
`else
`define PTC_ASSERT_IMP(lbl, clk, rst, a, c)
`define PTC_ASSERT_NEXT(lbl, clk, rst, a, c)
`endif

`endif

// ===== hw/rtl/ptc_pkg.sv =====
// ---------------------------------------------------------------------------
// ptc_pkg
// Shared types and constants of the pressure/temperature compensation block.
// ---------------------------------------------------------------------------
package ptc_pkg;

  // configuration register indexes
  typedef enum logic [1:0] {
    CAL_ZERO = 2'd0,
    CAL_ONE  = 2'd1,
    CAL_TWO  = 2'd2
  } cal_index_t;

  // formula constants
  localparam int unsigned T_OFFSET  = 128000;
  localparam int unsigned ADC_FULL  = 1048576;
  localparam int unsigned P_SCALE   = 3125;

  // unit latencies
  localparam int unsigned DIV_BITS  = 64;
  localparam int unsigned DIV_LAT   = DIV_BITS + 2;
  localparam int unsigned MUL_LAT   = 2;
  // start transfer to done strobe, in cycles
  localparam int unsigned PIPE_LAT  = 14 + DIV_LAT + MUL_LAT;

  // payload carried alongside the divider
  typedef struct packed {
    logic [31:0] centi;
    logic [31:0] fine;
    logic        ok;
  } div_side_t;

  // payload carried alongside the wide multiplier
  typedef struct packed {
    logic [31:0] centi;
    logic [31:0] fine;
    logic        ok;
    logic [63:0] p;
    logic [63:0] p8p;
  } mul_side_t;

endpackage

// ===== hw/rtl/ptc_div64.sv =====
// ---------------------------------------------------------------------------
// ptc_div64
// Pipelined signed 64-bit divider, one quotient bit per stage, truncating.
// ---------------------------------------------------------------------------
module ptc_div64 #(
  parameter int unsigned SIDE_W = 1
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  input  logic [63:0]       numer,
  input  logic [63:0]       denom,
  input  logic [SIDE_W-1:0] side_in,
  output logic              out_valid,
  output logic [63:0]       quot,
  output logic [SIDE_W-1:0] side_out
);

  localparam int unsigned N = ptc_pkg::DIV_BITS;

  logic              vld  [0:N];
  logic [63:0]       rem  [0:N];
  logic [63:0]       quo  [0:N];
  logic [63:0]       dvs  [0:N];
  logic              neg  [0:N];
  logic [SIDE_W-1:0] side [0:N];

  // entry: magnitudes and result sign
  always_ff @(posedge clk) begin
    if (rst) begin
      vld[0] <= 1'b0;
    end else begin
      vld[0] <= in_valid;
    end
    rem[0]  <= '0;
    quo[0]  <= numer[63] ? 64'd0 - numer : numer;
    dvs[0]  <= denom[63] ? 64'd0 - denom : denom;
    neg[0]  <= numer[63] ^ denom[63];
    side[0] <= side_in;
  end

  // restoring steps
  for (genvar k = 0; k < N; k++) begin : g_step
    logic [64:0] trial;
    logic [64:0] diff;
    logic        ge;

    always_comb begin
      trial = {rem[k], quo[k][63]};
      diff  = trial - {1'b0, dvs[k]};
      ge    = trial >= {1'b0, dvs[k]};
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        vld[k+1] <= 1'b0;
      end else begin
        vld[k+1] <= vld[k];
      end
      rem[k+1]  <= ge ? diff[63:0] : trial[63:0];
      quo[k+1]  <= {quo[k][62:0], ge};
      dvs[k+1]  <= dvs[k];
      neg[k+1]  <= neg[k];
      side[k+1] <= side[k];
    end
  end

  // exit: apply sign
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else begin
      out_valid <= vld[N];
    end
    quot     <= neg[N] ? 64'd0 - quo[N] : quo[N];
    side_out <= side[N];
  end

endmodule

// ===== hw/rtl/ptc_mul64.sv =====
// ---------------------------------------------------------------------------
// ptc_mul64
// Two-stage multiplier giving the low 64 bits of a 64 by 64 product.
// ---------------------------------------------------------------------------
module ptc_mul64 #(
  parameter int unsigned SIDE_W = 1
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  input  logic [63:0]       a,
  input  logic [63:0]       b,
  input  logic [SIDE_W-1:0] side_in,
  output logic              out_valid,
  output logic [63:0]       prod,
  output logic [SIDE_W-1:0] side_out
);

  logic              v1;
  logic [63:0]       ll;
  logic [31:0]       lh;
  logic [31:0]       hl;
  logic [SIDE_W-1:0] side1;
  logic [63:0]       lh_full;
  logic [63:0]       hl_full;

  assign lh_full = a[31:0] * b[63:32];
  assign hl_full = a[63:32] * b[31:0];

  // partial products
  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
    end else begin
      v1 <= in_valid;
    end
    ll    <= a[31:0] * b[31:0];
    lh    <= lh_full[31:0];
    hl    <= hl_full[31:0];
    side1 <= side_in;
  end

  // sum, cross terms only reach the upper half
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else begin
      out_valid <= v1;
    end
    prod     <= ll + {lh + hl, 32'd0};
    side_out <= side1;
  end

endmodule

// ===== hw/rtl/pressure_temperature_compensation.sv =====
// Each start transfer yields one done strobe at the end of the pipeline.
// Throughput: one reading pair per cycle; busy is always low, the pipeline
// never stalls and the receiver cannot hold results off.
// The 64-stage divider pipeline sets the latency.
// Reset (synchronous, active high) clears the calibration registers and all
// stage valid bits; results in flight are dropped.
// ---------------------------------------------------------------------------
// pressure_temperature_compensation
// Fixed-point temperature and pressure compensation of raw sensor readings.
// ---------------------------------------------------------------------------
`include "pressure_temperature_compensation_defines.svh"

module pressure_temperature_compensation (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [63:0] cfg_wdata,
  input  logic        start,
  output logic        busy,
  input  logic [19:0] raw_pressure,
  input  logic [19:0] raw_temperature,
  output logic        done,
  output logic signed [31:0] temperature_centi,
  output logic signed [31:0] fine_temperature,
  output logic [31:0] pressure_pa,
  output logic        pressure_valid
);

  // calibration registers
  logic [63:0] cal_word_zero;
  logic [63:0] cal_word_one;
  logic [63:0] cal_word_two;

  always_ff @(posedge clk) begin
    if (rst) begin
      cal_word_zero <= '0;
      cal_word_one  <= '0;
      cal_word_two  <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        ptc_pkg::CAL_ZERO: cal_word_zero <= cfg_wdata;
        ptc_pkg::CAL_ONE:  cal_word_one  <= cfg_wdata;
        ptc_pkg::CAL_TWO:  cal_word_two  <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // coefficient fields
  logic [31:0]        t1;
  logic [31:0]        t2;
  logic [31:0]        t3;
  logic signed [16:0] p1;
  logic signed [15:0] p2, p3, p4, p5, p6, p7, p8, p9;

  assign t1 = {16'd0, cal_word_zero[15:0]};
  assign t2 = {{16{cal_word_zero[31]}}, cal_word_zero[31:16]};
  assign t3 = {{16{cal_word_zero[47]}}, cal_word_zero[47:32]};
  assign p1 = $signed({1'b0, cal_word_zero[63:48]});
  assign p2 = $signed(cal_word_one[15:0]);
  assign p3 = $signed(cal_word_one[31:16]);
  assign p4 = $signed(cal_word_one[47:32]);
  assign p5 = $signed(cal_word_one[63:48]);
  assign p6 = $signed(cal_word_two[15:0]);
  assign p7 = $signed(cal_word_two[31:16]);
  assign p8 = $signed(cal_word_two[47:32]);
  assign p9 = $signed(cal_word_two[63:48]);

  assign busy = 1'b0;

  // input register
  logic        s0_v;
  logic [19:0] s0_adcp, s0_adct;

  always_ff @(posedge clk) begin
    if (rst) begin
      s0_v <= 1'b0;
    end else begin
      s0_v <= start && !busy;
    end
    s0_adcp <= raw_pressure;
    s0_adct <= raw_temperature;
  end

  // T1: offsets from T1
  logic        t1_v;
  logic [31:0] t1_d3, t1_d4;
  logic [19:0] t1_adcp;

  always_ff @(posedge clk) begin
    if (rst) begin
      t1_v <= 1'b0;
    end else begin
      t1_v <= s0_v;
    end
    t1_d3   <= {15'd0, s0_adct[19:3]} - {t1[30:0], 1'b0};
    t1_d4   <= {16'd0, s0_adct[19:4]} - t1;
    t1_adcp <= s0_adcp;
  end

  // T2: first products
  logic        t2_v;
  logic [31:0] t2_ma, t2_mb;
  logic [19:0] t2_adcp;
  logic [63:0] t2_ma_full, t2_mb_full;

  assign t2_ma_full = t1_d3 * t2;
  assign t2_mb_full = t1_d4 * t1_d4;

  always_ff @(posedge clk) begin
    if (rst) begin
      t2_v <= 1'b0;
    end else begin
      t2_v <= t1_v;
    end
    t2_ma   <= t2_ma_full[31:0];
    t2_mb   <= t2_mb_full[31:0];
    t2_adcp <= t1_adcp;
  end

  // T3: second-order term times T3
  logic        t3_v;
  logic [31:0] t3_ta, t3_x;
  logic [19:0] t3_adcp;
  logic [31:0] t3_mbs;
  logic [63:0] t3_x_full;

  assign t3_mbs    = $signed(t2_mb) >>> 12;
  assign t3_x_full = t3_mbs * t3;

  always_ff @(posedge clk) begin
    if (rst) begin
      t3_v <= 1'b0;
    end else begin
      t3_v <= t2_v;
    end
    t3_ta   <= $signed(t2_ma) >>> 11;
    t3_x    <= t3_x_full[31:0];
    t3_adcp <= t2_adcp;
  end

  // T4: fine temperature
  logic        t4_v;
  logic [31:0] t4_fine;
  logic [19:0] t4_adcp;
  logic [31:0] t4_tb;

  assign t4_tb = $signed(t3_x) >>> 14;

  always_ff @(posedge clk) begin
    if (rst) begin
      t4_v <= 1'b0;
    end else begin
      t4_v <= t3_v;
    end
    t4_fine <= t3_ta + t4_tb;
    t4_adcp <= t3_adcp;
  end

  // T5: centi-degrees and pressure offset term
  logic        t5_v;
  logic [31:0] t5_centi, t5_fine;
  logic [33:0] t5_v1;
  logic [19:0] t5_adcp;
  logic [31:0] t5_c;

  assign t5_c = {t4_fine[29:0], 2'b00} + t4_fine + 32'd128;

  always_ff @(posedge clk) begin
    if (rst) begin
      t5_v <= 1'b0;
    end else begin
      t5_v <= t4_v;
    end
    t5_centi <= $signed(t5_c) >>> 8;
    t5_fine  <= t4_fine;
    t5_v1    <= {{2{t4_fine[31]}}, t4_fine} - 34'(ptc_pkg::T_OFFSET);
    t5_adcp  <= t4_adcp;
  end

  // PA: products of the offset term
  logic        pa_v;
  logic [63:0] pa_vv, pa_vp5, pa_vp2;
  logic [31:0] pa_centi, pa_fine;
  logic [19:0] pa_adcp;
  logic signed [67:0] pa_sq;
  logic signed [49:0] pa_m5, pa_m2;

  assign pa_sq = $signed(t5_v1) * $signed(t5_v1);
  assign pa_m5 = $signed(t5_v1) * p5;
  assign pa_m2 = $signed(t5_v1) * p2;

  always_ff @(posedge clk) begin
    if (rst) begin
      pa_v <= 1'b0;
    end else begin
      pa_v <= t5_v;
    end
    pa_vv    <= pa_sq[63:0];
    pa_vp5   <= {{14{pa_m5[49]}}, pa_m5};
    pa_vp2   <= {{14{pa_m2[49]}}, pa_m2};
    pa_centi <= t5_centi;
    pa_fine  <= t5_fine;
    pa_adcp  <= t5_adcp;
  end

  // PB: coefficient products and shifted terms
  logic        pb_v;
  logic [63:0] pb_vvp6, pb_v2part, pb_vvp3, pb_v1b;
  logic [31:0] pb_centi, pb_fine;
  logic [19:0] pb_adcp;
  logic signed [79:0] pb_m6, pb_m3;
  logic [63:0] p4_ext;

  assign pb_m6  = $signed(pa_vv) * p6;
  assign pb_m3  = $signed(pa_vv) * p3;
  assign p4_ext = {{48{p4[15]}}, p4};

  always_ff @(posedge clk) begin
    if (rst) begin
      pb_v <= 1'b0;
    end else begin
      pb_v <= pa_v;
    end
    pb_vvp6   <= pb_m6[63:0];
    pb_vvp3   <= pb_m3[63:0];
    pb_v2part <= (pa_vp5 << 17) + (p4_ext << 35);
    pb_v1b    <= pa_vp2 << 12;
    pb_centi  <= pa_centi;
    pb_fine   <= pa_fine;
    pb_adcp   <= pa_adcp;
  end

  // PC: sums
  logic        pc_v;
  logic [63:0] pc_v2, pc_v1c;
  logic [31:0] pc_centi, pc_fine;
  logic [19:0] pc_adcp;
  logic [63:0] pc_s3;

  assign pc_s3 = $signed(pb_vvp3) >>> 8;

  always_ff @(posedge clk) begin
    if (rst) begin
      pc_v <= 1'b0;
    end else begin
      pc_v <= pb_v;
    end
    pc_v2    <= pb_vvp6 + pb_v2part;
    pc_v1c   <= pc_s3 + pb_v1b;
    pc_centi <= pb_centi;
    pc_fine  <= pb_fine;
    pc_adcp  <= pb_adcp;
  end

  // PD: divisor product and scaled numerator
  logic        pd_v;
  logic [63:0] pd_w, pd_num;
  logic [31:0] pd_centi, pd_fine;
  logic [63:0] pd_base, pd_shift, pd_diff;
  logic [20:0] pd_praw;
  logic signed [80:0] pd_mw;
  logic signed [76:0] pd_mn;

  assign pd_base  = 64'h0000_8000_0000_0000 + pc_v1c;
  assign pd_mw    = $signed(pd_base) * p1;
  assign pd_praw  = 21'(ptc_pkg::ADC_FULL) - {1'b0, pc_adcp};
  assign pd_shift = {43'd0, pd_praw} << 31;
  assign pd_diff  = pd_shift - pc_v2;
  assign pd_mn    = $signed(pd_diff) * $signed(13'(ptc_pkg::P_SCALE));

  always_ff @(posedge clk) begin
    if (rst) begin
      pd_v <= 1'b0;
    end else begin
      pd_v <= pc_v;
    end
    pd_w     <= pd_mw[63:0];
    pd_num   <= pd_mn[63:0];
    pd_centi <= pc_centi;
    pd_fine  <= pc_fine;
  end

  // division
  logic [63:0]        den;
  ptc_pkg::div_side_t dside_in, dside_out;
  logic               dv_v;
  logic [63:0]        dv_q;

  assign den = $signed(pd_w) >>> 33;

  always_comb begin
    dside_in.centi = pd_centi;
    dside_in.fine  = pd_fine;
    dside_in.ok    = den != 64'd0;
  end

  ptc_div64 #(
    .SIDE_W ($bits(ptc_pkg::div_side_t))
  ) u_div (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (pd_v),
    .numer     (pd_num),
    .denom     (den),
    .side_in   (dside_in),
    .out_valid (dv_v),
    .quot      (dv_q),
    .side_out  (dside_out)
  );

  // F: post-division terms
  logic               f_v;
  logic [63:0]        f_q13;
  ptc_pkg::mul_side_t f_side;
  logic signed [79:0] f_m8;

  assign f_m8 = $signed(dv_q) * p8;

  always_ff @(posedge clk) begin
    if (rst) begin
      f_v <= 1'b0;
    end else begin
      f_v <= dv_v;
    end
    f_q13        <= $signed(dv_q) >>> 13;
    f_side.centi <= dside_out.centi;
    f_side.fine  <= dside_out.fine;
    f_side.ok    <= dside_out.ok;
    f_side.p     <= dv_q;
    f_side.p8p   <= f_m8[63:0];
  end

  // square of the scaled quotient
  logic               m_v;
  logic [63:0]        m_sq;
  ptc_pkg::mul_side_t m_side;

  ptc_mul64 #(
    .SIDE_W ($bits(ptc_pkg::mul_side_t))
  ) u_mul (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (f_v),
    .a         (f_q13),
    .b         (f_q13),
    .side_in   (f_side),
    .out_valid (m_v),
    .prod      (m_sq),
    .side_out  (m_side)
  );

  // H: times P9
  logic               h_v;
  logic [63:0]        h_r;
  ptc_pkg::mul_side_t h_side;
  logic signed [79:0] h_m9;

  assign h_m9 = $signed(m_sq) * p9;

  always_ff @(posedge clk) begin
    if (rst) begin
      h_v <= 1'b0;
    end else begin
      h_v <= m_v;
    end
    h_r    <= h_m9[63:0];
    h_side <= m_side;
  end

  // I: correction sum
  logic        i_v;
  logic [63:0] i_s;
  logic [31:0] i_centi, i_fine;
  logic        i_ok;
  logic [63:0] i_a, i_b;

  assign i_a = $signed(h_r) >>> 25;
  assign i_b = $signed(h_side.p8p) >>> 19;

  always_ff @(posedge clk) begin
    if (rst) begin
      i_v <= 1'b0;
    end else begin
      i_v <= h_v;
    end
    i_s     <= h_side.p + i_a + i_b;
    i_centi <= h_side.centi;
    i_fine  <= h_side.fine;
    i_ok    <= h_side.ok;
  end

  // J: final offset and output register
  logic [63:0] j_pp;
  logic [63:0] p7_ext;

  assign p7_ext = {{48{p7[15]}}, p7};
  assign j_pp   = ($signed(i_s) >>> 8) + (p7_ext << 4);

  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= i_v;
    end
    temperature_centi <= i_centi;
    fine_temperature  <= i_fine;
    pressure_pa       <= i_ok ? j_pp[39:8] : 32'd0;
    pressure_valid    <= i_ok;
  end

  // checks
  `PTC_ASSERT_IMP(a_latency, clk, rst, start && !busy, ##(ptc_pkg::PIPE_LAT) done)
  `PTC_ASSERT_IMP(a_zero_pressure, clk, rst, done && !pressure_valid, pressure_pa == 32'd0)
  `PTC_ASSERT_IMP(a_reset_flush, clk, rst, $past(rst), !done)

endmodule

// ===== sim/tb.sv =====
// ---------------------------------------------------------------------------
// tb: pressure/temperature compensation testbench
// Drives raw reading pairs under several calibration sets, predicts the
// compensated temperature and pressure in 32/64-bit wrapping arithmetic,
// and checks every done strobe in order against the predicted values.
// ---------------------------------------------------------------------------
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned LIMIT_CYCLES = 400000;
  localparam int unsigned DRAIN_CYCLES = ptc_pkg::PIPE_LAT + 20;

  typedef struct packed {
    logic [19:0] pres;
    logic [19:0] temp;
  } reading_t;

  typedef struct packed {
    logic [31:0] centi;
    logic [31:0] fine;
    logic [31:0] pa;
    logic        ok;
  } comp_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        cfg_we = 1'b0;
  logic [1:0]  cfg_index = ptc_pkg::CAL_ZERO;
  logic [63:0] cfg_wdata = '0;
  logic        start = 1'b0;
  logic        busy;
  logic [19:0] raw_pressure = '0;
  logic [19:0] raw_temperature = '0;
  logic        done;
  logic signed [31:0] temperature_centi;
  logic signed [31:0] fine_temperature;
  logic [31:0] pressure_pa;
  logic        pressure_valid;

  logic [63:0] cal_w0, cal_w1, cal_w2;
  reading_t    pending_q[$];
  comp_t       expected_q[$];
  int unsigned cycle_count = 0;
  bit          failed = 1'b0;

  pressure_temperature_compensation uut (.*);

  // clock
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic logic [63:0] sext16(logic [63:0] w, int pos);
    logic [15:0] f;
    f = w[pos +: 16];
    return {{48{f[15]}}, f};
  endfunction

  // compensate one reading pair under the current calibration
  function automatic comp_t compensate(reading_t r);
    comp_t c;
    logic signed [31:0] t1, t2, t3, d3, d4, ta, tb32, fine;
    logic signed [63:0] p1, p2, p3, p4, p5, p6, p7, p8, p9;
    logic signed [63:0] v1, v2, p, q13, an, ad, q;
    t1 = {16'd0, cal_w0[15:0]};
    t2 = 32'(sext16(cal_w0, 16));
    t3 = 32'(sext16(cal_w0, 32));
    p1 = {48'd0, cal_w0[63:48]};
    p2 = sext16(cal_w1, 0);  p3 = sext16(cal_w1, 16);
    p4 = sext16(cal_w1, 32); p5 = sext16(cal_w1, 48);
    p6 = sext16(cal_w2, 0);  p7 = sext16(cal_w2, 16);
    p8 = sext16(cal_w2, 32); p9 = sext16(cal_w2, 48);
    d3 = {12'd0, r.temp} >>> 3;
    d3 = d3 - (t1 << 1);
    ta = (d3 * t2) >>> 11;
    d4 = ({12'd0, r.temp} >>> 4) - t1;
    tb32 = (((d4 * d4) >>> 12) * t3) >>> 14;
    fine = ta + tb32;
    c.fine = fine;
    c.centi = (fine * 32'sd5 + 32'sd128) >>> 8;
    c.pa = '0;
    c.ok = 1'b0;
    v1 = 64'(fine) - 64'sd128000;
    v2 = v1 * v1 * p6;
    v2 = v2 + ((v1 * p5) << 17);
    v2 = v2 + (p4 << 35);
    v1 = ((v1 * v1 * p3) >>> 8) + ((v1 * p2) << 12);
    v1 = (((64'sd1 << 47) + v1) * p1) >>> 33;
    if (v1 != 0) begin
      p = 64'sd1048576 - {44'd0, r.pres};
      p = ((p << 31) - v2) * 64'sd3125;
      // truncating division on magnitudes, min/-1 wraps
      an = p[63] ? -p : p;
      ad = v1[63] ? -v1 : v1;
      q = $signed($unsigned(an) / $unsigned(ad));
      p = (p[63] != v1[63]) ? -q : q;
      q13 = p >>> 13;
      v1 = (p9 * q13 * q13) >>> 25;
      v2 = (p8 * p) >>> 19;
      p = ((p + v1 + v2) >>> 8) + (p7 << 4);
      c.pa = 32'(p >>> 8);
      c.ok = 1'b1;
    end
    return c;
  endfunction

  function automatic int unsigned gap_len();
    int unsigned k;
    k = $urandom_range(0, 99);
    if (k < 40) return 0;
    if (k < 90) return $urandom_range(1, 3);
    return $urandom_range(4, 30);
  endfunction

  // driver: one transfer per cycle when no gap is pending and busy is low
  int unsigned gap = 0;
  bit          stall_phase = 1'b0;
  always @(negedge clk) begin
    if (rst) begin
      start <= 1'b0;
    end else if (start && busy) begin
      // hold the item until it is taken
    end else begin
      if (gap != 0) begin
        gap <= gap - 1;
        start <= 1'b0;
      end else if (pending_q.size() != 0) begin
        reading_t r;
        r = pending_q.pop_front();
        raw_pressure <= r.pres;
        raw_temperature <= r.temp;
        start <= 1'b1;
        gap <= stall_phase ? gap_len() : 0;
      end else begin
        start <= 1'b0;
      end
    end
  end

  // monitor: predict on start transfer, check on done strobe
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (!rst) begin
      if (start && !busy)
        expected_q.push_back(compensate('{pres: raw_pressure, temp: raw_temperature}));
      if (done) begin
        if (expected_q.size() == 0) begin
          $display("%0t: unexpected result centi=%0d", $time, temperature_centi);
          failed = 1'b1;
        end else begin
          comp_t e;
          e = expected_q.pop_front();
          if (e.centi !== temperature_centi || e.fine !== fine_temperature ||
              e.pa !== pressure_pa || e.ok !== pressure_valid) begin
            $display("%0t: mismatch exp centi=%0d fine=%0d pa=%0d ok=%0b",
                     $time, $signed(e.centi), $signed(e.fine), e.pa, e.ok);
            $display("%0t:          got centi=%0d fine=%0d pa=%0d ok=%0b",
                     $time, temperature_centi, fine_temperature, pressure_pa,
                     pressure_valid);
            failed = 1'b1;
          end
        end
      end
    end
    if (cycle_count > LIMIT_CYCLES) begin
      $display("tb failed");
      $finish;
    end
  end

  task automatic write_cal(ptc_pkg::cal_index_t idx, logic [63:0] val);
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(negedge clk);
    cfg_we <= 1'b0;
    case (idx)
      ptc_pkg::CAL_ZERO: cal_w0 = val;
      ptc_pkg::CAL_ONE:  cal_w1 = val;
      default:           cal_w2 = val;
    endcase
  endtask

  // wait until every item is sent and checked, then let the pipe settle
  task automatic drain();
    while (pending_q.size() != 0 || start || expected_q.size() != 0)
      @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  function automatic logic [19:0] rand20();
    case ($urandom_range(0, 5))
      0: return 20'h00000;
      1: return 20'hFFFFF;
      default: return 20'($urandom);
    endcase
  endfunction

  // typical calibration with random trim, keeps the pressure path well formed
  function automatic logic [63:0] typ_w0();
    return {16'(36477 + $urandom_range(0, 2000) - 1000),
            16'(-16'sd1000 + 16'($urandom_range(0, 500))),
            16'(26435 + $urandom_range(0, 2000) - 1000),
            16'(27504 + $urandom_range(0, 2000) - 1000)};
  endfunction

  initial begin
    logic [63:0] w0, w1, w2;
    cal_w0 = '0; cal_w1 = '0; cal_w2 = '0;
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // reset calibration: every result takes the zero divisor path
    pending_q.push_back('{pres: 20'h00000, temp: 20'h00000});
    pending_q.push_back('{pres: 20'hFFFFF, temp: 20'hFFFFF});
    pending_q.push_back('{pres: 20'h65A00, temp: 20'h7E500});
    drain();

    // typical calibration, directed extremes
    write_cal(ptc_pkg::CAL_ZERO, {16'd36477, 16'hFC18, 16'd26435, 16'd27504});
    write_cal(ptc_pkg::CAL_ONE, {16'hFFF9, 16'h2710, 16'h0B8C, 16'hD6D0});
    write_cal(ptc_pkg::CAL_TWO, {16'h1770, 16'hC3B6, 16'h3AF3, 16'hFFF9});
    // unknown index is ignored by the block
    @(negedge clk);
    cfg_we <= 1'b1; cfg_index <= 2'd3; cfg_wdata <= '1;
    @(negedge clk);
    cfg_we <= 1'b0;
    pending_q.push_back('{pres: 20'h00000, temp: 20'h00000});
    pending_q.push_back('{pres: 20'hFFFFF, temp: 20'hFFFFF});
    pending_q.push_back('{pres: 20'h00000, temp: 20'hFFFFF});
    pending_q.push_back('{pres: 20'hFFFFF, temp: 20'h00000});
    pending_q.push_back('{pres: 20'h65A00, temp: 20'h7E500});
    pending_q.push_back('{pres: 20'h80000, temp: 20'h80000});
    drain();

    // extreme calibration: all ones, then sign bits only in the first two words and all but the sign bits in the third
    write_cal(ptc_pkg::CAL_ZERO, '1);
    write_cal(ptc_pkg::CAL_ONE, '1);
    write_cal(ptc_pkg::CAL_TWO, '1);
    for (int i = 0; i < 4; i++) pending_q.push_back('{pres: rand20(), temp: rand20()});
    drain();
    write_cal(ptc_pkg::CAL_ZERO, 64'h8000_8000_8000_8000);
    write_cal(ptc_pkg::CAL_ONE, 64'h8000_8000_8000_8000);
    write_cal(ptc_pkg::CAL_TWO, 64'h7FFF_7FFF_7FFF_7FFF);
    for (int i = 0; i < 4; i++) pending_q.push_back('{pres: rand20(), temp: rand20()});
    drain();

    // random phases: mostly realistic trims, some fully random words
    for (int ph = 0; ph < 8; ph++) begin
      stall_phase = ph[0];
      if (ph % 3 == 2) begin
        w0 = {$urandom, $urandom}; w1 = {$urandom, $urandom}; w2 = {$urandom, $urandom};
      end else begin
        w0 = typ_w0();
        w1 = {16'($urandom_range(0, 400) - 200), 16'($urandom_range(0, 20000)),
              16'($urandom_range(0, 4000)), 16'(-16'sd10000 - 16'($urandom_range(0, 2000)))};
        w2 = {16'($urandom_range(0, 12000)), 16'(-16'sd15000 - 16'($urandom_range(0, 1000))),
              16'($urandom_range(0, 20000)), 16'($urandom_range(0, 20) - 10)};
      end
      write_cal(ptc_pkg::CAL_ZERO, w0);
      write_cal(ptc_pkg::CAL_ONE, w1);
      write_cal(ptc_pkg::CAL_TWO, w2);
      for (int i = 0; i < 50; i++) pending_q.push_back('{pres: rand20(), temp: rand20()});
      drain();
    end

    if (!failed) begin
      $display("tb passed");
    end else begin
      $display("tb failed");
    end
    $finish;
  end
endmodule
